### hdl/spi_mbe_pkg.sv
`timescale 1ns / 1ps

package spi_mbe_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPI_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_ACT_LOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 3'd3;

  // opcodes
  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_XFER    = 3'd2;
  localparam logic [2:0] OP_SELECT  = 3'd3;
  localparam logic [2:0] OP_RELEASE = 3'd4;

  typedef enum logic [1:0] {
    CK_NONE,
    CK_BYTE,
    CK_SELECT,
    CK_RELEASE
  } cmd_kind_t;

  typedef struct packed {
    logic      cmd;
    cmd_kind_t kind;
    logic      rx_wanted;
    logic      is_read;
    logic [7:0] tx_byte;
    logic      miso;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

endpackage

### hdl/spi_mbe_channels.sv
`timescale 1ns / 1ps

interface spi_mbe_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] opcode;
  logic [7:0] tx_byte;
  logic       miso_level;

  modport source (output valid, cmd_valid, opcode, tx_byte, miso_level, input ready);
  modport sink (input valid, cmd_valid, opcode, tx_byte, miso_level, output ready);
endinterface

interface spi_mbe_out_if;
  logic       valid;
  logic       ready;
  logic       sck_level;
  logic       mosi_level;
  logic       select_level;
  logic       busy_res;
  logic       done_res;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       status;

  modport source (output valid, sck_level, mosi_level, select_level, busy_res, done_res,
                  rx_valid, rx_byte, status, input ready);
  modport sink (input valid, sck_level, mosi_level, select_level, busy_res, done_res,
                rx_valid, rx_byte, status, output ready);
endinterface

interface spi_mbe_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [spi_mbe_pkg::CFG_IDX_W-1:0]  index;
  logic [spi_mbe_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/spi_mbe_front.sv
`timescale 1ns / 1ps

module spi_mbe_front (
  spi_mbe_in_if.sink          in_if,
  input  logic                q_full,
  output spi_mbe_pkg::push_t  push_o
);

  spi_mbe_pkg::item_t item;

  // classify the tick
  always_comb begin
    item.cmd       = in_if.cmd_valid;
    item.kind      = spi_mbe_pkg::CK_NONE;
    item.rx_wanted = 1'b0;
    item.is_read   = 1'b0;
    item.tx_byte   = in_if.tx_byte;
    item.miso      = in_if.miso_level;
    if (in_if.cmd_valid) begin
      case (in_if.opcode)
        spi_mbe_pkg::OP_WRITE: begin
          item.kind = spi_mbe_pkg::CK_BYTE;
        end
        spi_mbe_pkg::OP_READ: begin
          item.kind      = spi_mbe_pkg::CK_BYTE;
          item.rx_wanted = 1'b1;
          item.is_read   = 1'b1;
        end
        spi_mbe_pkg::OP_XFER: begin
          item.kind      = spi_mbe_pkg::CK_BYTE;
          item.rx_wanted = 1'b1;
        end
        spi_mbe_pkg::OP_SELECT: begin
          item.kind = spi_mbe_pkg::CK_SELECT;
        end
        spi_mbe_pkg::OP_RELEASE: begin
          item.kind = spi_mbe_pkg::CK_RELEASE;
        end
        default: begin
          item.kind = spi_mbe_pkg::CK_NONE;
        end
      endcase
    end
  end

  assign in_if.ready = !q_full;
  assign push_o.push = in_if.valid && !q_full;
  assign push_o.item = item;

endmodule

### hdl/spi_mbe_queue.sv
`timescale 1ns / 1ps

module spi_mbe_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  spi_mbe_pkg::push_t  push_i,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output spi_mbe_pkg::item_t  head
);

  localparam int DEPTH = spi_mbe_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  spi_mbe_pkg::item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign do_pop = pop && !empty;
  assign head   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      mem[wr_ptr_r] <= push_i.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i.push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push_i.push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### hdl/spi_mbe_back.sv
`timescale 1ns / 1ps

module spi_mbe_back #(
  parameter int COUNTER_WIDTH = spi_mbe_pkg::COUNTER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  spi_mbe_pkg::item_t head,
  output logic               pop,
  spi_mbe_out_if.source      out_if,
  spi_mbe_cfg_if.sink        cfg_if
);

  localparam int CW = COUNTER_WIDTH;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SETTLE,
    PH_LEAD,
    PH_TRAIL
  } phase_t;

  typedef struct packed {
    logic       sck_level;
    logic       mosi_level;
    logic       select_level;
    logic       busy_res;
    logic       done_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       status;
  } result_t;

  // configuration
  logic [1:0]  mode_r;
  logic        msb_r;
  logic        sal_r;
  logic [15:0] hp_r;

  // engine state
  phase_t      phase_r, phase_nxt;
  logic        rxw_r, rxw_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [CW-1:0] wait_r, wait_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        clk_r, clk_nxt;
  logic        dat_r, dat_nxt;
  logic        sel_r, sel_nxt;

  logic        out_valid_r, out_valid_nxt;
  result_t     out_r, res;

  logic        cfg_we;
  logic        cpol, cpha;
  logic [CW-1:0] half;
  logic [2:0]  pos;

  function automatic logic [CW-1:0] half_ticks(input logic [15:0] hp);
    logic [31:0] h;
    logic [31:0] lim;
    h   = {16'd0, hp};
    lim = 32'((64'd1 << CW) - 64'd1);
    if (h == 32'd0) h = 32'd1;
    if (h > lim) h = lim;
    return h[CW-1:0];
  endfunction

  function automatic logic [2:0] bit_place(input logic msb, input logic [2:0] idx);
    return msb ? (3'd7 - idx) : idx;
  endfunction

  assign cfg_we        = cfg_if.valid;
  assign cfg_if.ready  = 1'b1;
  assign cpol          = mode_r[1];
  assign cpha          = mode_r[0];
  assign half          = half_ticks(hp_r);
  assign pos           = bit_place(msb_r, bit_r);
  assign pop           = !q_empty && !cfg_we && (!out_valid_r || out_if.ready);
  assign out_valid_nxt = pop ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_comb begin
    phase_nxt = phase_r;
    rxw_nxt   = rxw_r;
    bit_nxt   = bit_r;
    wait_nxt  = wait_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    clk_nxt   = clk_r;
    dat_nxt   = dat_r;
    sel_nxt   = sel_r;
    res       = '0;
    if (phase_r == PH_IDLE) begin
      if (head.cmd) begin
        case (head.kind)
          spi_mbe_pkg::CK_BYTE: begin
            rxw_nxt   = head.rx_wanted;
            tx_nxt    = head.is_read ? 8'd0 : head.tx_byte;
            rx_nxt    = 8'd0;
            bit_nxt   = 3'd0;
            dat_nxt   = tx_nxt[bit_place(msb_r, 3'd0)];
            if (cpha) clk_nxt = !cpol;
            phase_nxt = PH_LEAD;
            wait_nxt  = half;
          end
          spi_mbe_pkg::CK_SELECT: begin
            sel_nxt   = !sal_r;
            phase_nxt = PH_SETTLE;
            wait_nxt  = CW'(1);
          end
          spi_mbe_pkg::CK_RELEASE: begin
            sel_nxt   = sal_r;
            phase_nxt = PH_SETTLE;
            wait_nxt  = CW'(1);
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end else begin
      res.status = head.cmd;
      if (phase_r == PH_SETTLE) begin
        phase_nxt    = PH_IDLE;
        wait_nxt     = '0;
        res.done_res = 1'b1;
      end else if (wait_r > CW'(1)) begin
        wait_nxt = wait_r - 1'b1;
      end else if (phase_r == PH_LEAD) begin
        clk_nxt = cpha ? cpol : !cpol;
        if (head.miso) rx_nxt[pos] = 1'b1;
        phase_nxt = PH_TRAIL;
        wait_nxt  = half;
      end else begin
        clk_nxt = cpol;
        if (bit_r == 3'd7) begin
          phase_nxt    = PH_IDLE;
          wait_nxt     = '0;
          res.done_res = 1'b1;
          if (rxw_r) begin
            res.rx_valid = 1'b1;
            res.rx_byte  = rx_r;
          end
        end else begin
          bit_nxt   = bit_r + 1'b1;
          dat_nxt   = tx_r[bit_place(msb_r, bit_nxt)];
          if (cpha) clk_nxt = !cpol;
          phase_nxt = PH_LEAD;
          wait_nxt  = half;
        end
      end
    end
    res.sck_level    = clk_nxt;
    res.mosi_level   = dat_nxt;
    res.select_level = sel_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 2'd0;
      msb_r       <= 1'b1;
      sal_r       <= 1'b1;
      hp_r        <= 16'd1;
      phase_r     <= PH_IDLE;
      rxw_r       <= 1'b0;
      bit_r       <= 3'd0;
      wait_r      <= '0;
      tx_r        <= 8'd0;
      rx_r        <= 8'd0;
      clk_r       <= 1'b0;
      dat_r       <= 1'b0;
      sel_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_if.index)
          spi_mbe_pkg::REG_SPI_MODE: begin
            mode_r  <= cfg_if.data[1:0];
            phase_r <= PH_IDLE;
            wait_r  <= '0;
            clk_r   <= cfg_if.data[1];
            dat_r   <= 1'b0;
            sel_r   <= sal_r;
          end
          spi_mbe_pkg::REG_MSB_FIRST: begin
            msb_r <= cfg_if.data[0];
          end
          spi_mbe_pkg::REG_SEL_ACT_LOW: begin
            sal_r   <= cfg_if.data[0];
            phase_r <= PH_IDLE;
            wait_r  <= '0;
            clk_r   <= cpol;
            dat_r   <= 1'b0;
            sel_r   <= cfg_if.data[0];
          end
          spi_mbe_pkg::REG_HALF_PERIOD: begin
            hp_r <= cfg_if.data[15:0];
          end
          default: begin
            hp_r <= hp_r;
          end
        endcase
      end else if (pop) begin
        phase_r <= phase_nxt;
        rxw_r   <= rxw_nxt;
        bit_r   <= bit_nxt;
        wait_r  <= wait_nxt;
        tx_r    <= tx_nxt;
        rx_r    <= rx_nxt;
        clk_r   <= clk_nxt;
        dat_r   <= dat_nxt;
        sel_r   <= sel_nxt;
        out_r   <= res;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.sck_level    = out_r.sck_level;
  assign out_if.mosi_level   = out_r.mosi_level;
  assign out_if.select_level = out_r.select_level;
  assign out_if.busy_res     = out_r.busy_res;
  assign out_if.done_res     = out_r.done_res;
  assign out_if.rx_valid     = out_r.rx_valid;
  assign out_if.rx_byte      = out_r.rx_byte;
  assign out_if.status       = out_r.status;

  a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (wait_r == '0))
    else $error("wait count left running while idle");

  a_rx_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.rx_valid) |-> out_r.done_res)
    else $error("received byte reported without completion");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_res) |-> !out_r.busy_res)
    else $error("completion reported while still busy");

  a_last_bit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !cfg_we && phase_r == PH_TRAIL && wait_r <= CW'(1) && bit_r == 3'd7)
    |=> (phase_r == PH_IDLE))
    else $error("byte did not finish after the eighth bit");

endmodule

### hdl/spi_master_byte_engine.sv
`timescale 1ns / 1ps

// spi master for modes 0 to 3: every input transaction is one time tick and yields exactly
// one result transaction with the pin levels, busy, done, received byte and status for that
// tick. one tick is taken every clock cycle while the queue is not full; a tick is classified
// on entry, waits in a two-entry queue and is executed by the tick engine, which registers
// the result, so each result passes through the queue and the engine's result register
// before it is presented. a byte completes 16 * half_period_ticks ticks after its command
// tick, select and release one settle tick after the command. configuration writes are taken
// every cycle and hold the engine for that cycle; writing the mode or the select polarity
// aborts any transfer and returns the pins to their idle levels.
module spi_master_byte_engine #(
  parameter int COUNTER_WIDTH = spi_mbe_pkg::COUNTER_WIDTH_DEF
) (
  input logic           clk,
  input logic           rst_n,
  spi_mbe_in_if.sink    in_if,
  spi_mbe_out_if.source out_if,
  spi_mbe_cfg_if.sink   cfg_if
);

  spi_mbe_pkg::push_t push;
  spi_mbe_pkg::item_t head;
  logic               q_full;
  logic               q_empty;
  logic               pop;

  spi_mbe_front u_front (
    .in_if  (in_if),
    .q_full (q_full),
    .push_o (push)
  );

  spi_mbe_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .full   (q_full),
    .pop    (pop),
    .empty  (q_empty),
    .head   (head)
  );

  spi_mbe_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_if  (out_if),
    .cfg_if  (cfg_if)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 40;
  localparam int RANDOM_TICKS = 1600;

  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
  localparam logic [spi_mbe_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef enum logic [1:0] {ENG_IDLE, ENG_SETTLE, ENG_LEAD, ENG_TRAIL} eng_phase_t;
  typedef enum logic [1:0] {MISO_RANDOM, MISO_HIGH, MISO_LOW} miso_drive_t;

  typedef struct packed {
    logic       sck;
    logic       mosi;
    logic       sel;
    logic       busy;
    logic       done;
    logic       rxv;
    logic [7:0] rxb;
    logic       stat;
  } pin_state_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spi_mbe_in_if  in_ch ();
  spi_mbe_out_if out_ch ();
  spi_mbe_cfg_if cfg_ch ();

  spi_master_byte_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // shadow of the engine
  logic [1:0]  cfg_mode;
  logic        cfg_msb;
  logic        cfg_sel_low;
  logic [15:0] cfg_half;
  eng_phase_t  eng_phase;
  logic [2:0]  eng_op;
  logic [2:0]  eng_bit;
  logic [15:0] eng_wait;
  logic [7:0]  eng_tx;
  logic [7:0]  eng_rx;
  logic        eng_sck;
  logic        eng_mosi;
  logic        eng_sel;

  pin_state_t  predicted_pins[$];
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  int unsigned noise_pct = 0;
  miso_drive_t miso_drive = MISO_RANDOM;

  function automatic logic [15:0] half_len();
    return (cfg_half == 16'd0) ? 16'd1 : cfg_half;
  endfunction

  function automatic logic [2:0] bit_slot();
    return cfg_msb ? (3'd7 - eng_bit) : eng_bit;
  endfunction

  function automatic void launch_bit();
    eng_mosi = (eng_op == spi_mbe_pkg::OP_READ) ? 1'b0 : eng_tx[bit_slot()];
    if (cfg_mode[0]) eng_sck = ~cfg_mode[1];
    eng_phase = ENG_LEAD;
    eng_wait = half_len();
  endfunction

  function automatic void park_pins();
    eng_phase = ENG_IDLE;
    eng_wait = 16'd0;
    eng_sck = cfg_mode[1];
    eng_mosi = 1'b0;
    eng_sel = cfg_sel_low;
  endfunction

  function automatic void reset_shadow();
    cfg_mode = 2'd0;
    cfg_msb = 1'b1;
    cfg_sel_low = 1'b1;
    cfg_half = 16'd1;
    eng_op = spi_mbe_pkg::OP_WRITE;
    eng_bit = 3'd0;
    eng_tx = 8'h00;
    eng_rx = 8'h00;
    park_pins();
  endfunction

  function automatic void apply_reg(logic [spi_mbe_pkg::CFG_IDX_W-1:0] idx,
                                    logic [spi_mbe_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      spi_mbe_pkg::REG_SPI_MODE: begin
        cfg_mode = val[1:0];
        park_pins();
      end
      spi_mbe_pkg::REG_MSB_FIRST: cfg_msb = val[0];
      spi_mbe_pkg::REG_SEL_ACT_LOW: begin
        cfg_sel_low = val[0];
        park_pins();
      end
      spi_mbe_pkg::REG_HALF_PERIOD: cfg_half = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic pin_state_t spi_tick(logic cmd, logic [2:0] opc, logic [7:0] txb,
                                          logic miso);
    pin_state_t r;
    r = '0;
    if (eng_phase == ENG_IDLE) begin
      if (cmd) begin
        if (opc == spi_mbe_pkg::OP_WRITE || opc == spi_mbe_pkg::OP_READ ||
            opc == spi_mbe_pkg::OP_XFER) begin
          eng_op = opc;
          eng_tx = (opc == spi_mbe_pkg::OP_READ) ? 8'h00 : txb;
          eng_rx = 8'h00;
          eng_bit = 3'd0;
          launch_bit();
        end else if (opc == spi_mbe_pkg::OP_SELECT || opc == spi_mbe_pkg::OP_RELEASE) begin
          eng_op = opc;
          eng_sel = (opc == spi_mbe_pkg::OP_SELECT) ^ cfg_sel_low;
          eng_phase = ENG_SETTLE;
          eng_wait = 16'd1;
        end
      end
    end else begin
      r.stat = cmd;
      if (eng_phase == ENG_SETTLE) begin
        eng_phase = ENG_IDLE;
        eng_wait = 16'd0;
        r.done = 1'b1;
      end else if (eng_wait > 16'd1) begin
        eng_wait = eng_wait - 16'd1;
      end else if (eng_phase == ENG_LEAD) begin
        eng_sck = cfg_mode[0] ? cfg_mode[1] : ~cfg_mode[1];
        if (miso) eng_rx[bit_slot()] = 1'b1;
        eng_phase = ENG_TRAIL;
        eng_wait = half_len();
      end else begin
        eng_sck = cfg_mode[1];
        if (eng_bit == 3'd7) begin
          eng_phase = ENG_IDLE;
          eng_wait = 16'd0;
          r.done = 1'b1;
          if (eng_op == spi_mbe_pkg::OP_READ || eng_op == spi_mbe_pkg::OP_XFER) begin
            r.rxv = 1'b1;
            r.rxb = eng_rx;
          end
        end else begin
          eng_bit = eng_bit + 3'd1;
          launch_bit();
        end
      end
    end
    r.sck = eng_sck;
    r.mosi = eng_mosi;
    r.sel = eng_sel;
    r.busy = (eng_phase != ENG_IDLE);
    return r;
  endfunction

  function automatic logic draw_miso();
    case (miso_drive)
      MISO_HIGH: return 1'b1;
      MISO_LOW:  return 1'b0;
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic send_tick(input logic cmd, input logic [2:0] opc, input logic [7:0] txb,
                           input logic miso);
    int unsigned gap;
    gap = in_idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd_valid  <= cmd;
    in_ch.opcode     <= opc;
    in_ch.tx_byte    <= txb;
    in_ch.miso_level <= miso;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted_pins.push_back(spi_tick(cmd, opc, txb, miso));
    ticks_sent++;
  endtask

  task automatic idle_ticks(input int unsigned n);
    repeat (n) send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), draw_miso());
  endtask

  // keeps ticking until the engine is idle, optionally hitting the completing tick
  task automatic run_out(input bit poke_last);
    bit last;
    logic cmd;
    while (eng_phase != ENG_IDLE) begin
      last = (eng_phase == ENG_SETTLE) ||
             (eng_phase == ENG_TRAIL && eng_bit == 3'd7 && eng_wait <= 16'd1);
      cmd = (poke_last && last) || ($urandom_range(0, 99) < noise_pct);
      send_tick(cmd, 3'($urandom_range(0, 7)), 8'($urandom), draw_miso());
    end
  endtask

  task automatic issue(input logic [2:0] opc, input logic [7:0] txb, input bit poke_last);
    send_tick(1'b1, opc, txb, draw_miso());
    run_out(poke_last);
  endtask

  task automatic write_reg(input logic [spi_mbe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [spi_mbe_pkg::CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (predicted_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic test_reset_levels();
    idle_ticks(3);
  endtask

  task automatic test_directed_commands();
    issue(spi_mbe_pkg::OP_SELECT, 8'h00, 1'b1);
    miso_drive = MISO_HIGH;
    issue(spi_mbe_pkg::OP_READ, 8'h00, 1'b0);
    miso_drive = MISO_LOW;
    issue(spi_mbe_pkg::OP_WRITE, 8'hFF, 1'b1);
    issue(spi_mbe_pkg::OP_XFER, 8'h00, 1'b0);
    miso_drive = MISO_RANDOM;
    issue(spi_mbe_pkg::OP_XFER, 8'hA5, 1'b0);
    send_tick(1'b1, OP_RSVD_FIRST, 8'h00, 1'b0);
    send_tick(1'b1, OP_RSVD_LAST, 8'hFF, 1'b1);
    issue(spi_mbe_pkg::OP_RELEASE, 8'h00, 1'b0);
    write_reg(spi_mbe_pkg::REG_MSB_FIRST, 16'h0000);
    issue(spi_mbe_pkg::OP_XFER, 8'h01, 1'b0);
    issue(spi_mbe_pkg::OP_READ, 8'h5A, 1'b0);
    write_reg(spi_mbe_pkg::REG_HALF_PERIOD, 16'h0000);
    issue(spi_mbe_pkg::OP_XFER, 8'h80, 1'b0);
  endtask

  task automatic test_config_abort();
    write_reg(spi_mbe_pkg::REG_HALF_PERIOD, 16'hFFFF);
    send_tick(1'b1, spi_mbe_pkg::OP_WRITE, 8'hC3, 1'b1);
    idle_ticks(20);
    write_reg(spi_mbe_pkg::REG_SPI_MODE, 16'hFFF1);
    idle_ticks(2);
    write_reg(spi_mbe_pkg::REG_HALF_PERIOD, 16'd2);
    send_tick(1'b1, spi_mbe_pkg::OP_XFER, 8'h3C, draw_miso());
    idle_ticks(7);
    write_reg(spi_mbe_pkg::REG_MSB_FIRST, 16'h0001);
    idle_ticks(5);
    write_reg(spi_mbe_pkg::REG_HALF_PERIOD, 16'd3);
    run_out(1'b0);
    write_reg(spi_mbe_pkg::REG_SEL_ACT_LOW, 16'h0000);
    issue(spi_mbe_pkg::OP_SELECT, 8'h00, 1'b0);
    send_tick(1'b1, spi_mbe_pkg::OP_READ, 8'h00, draw_miso());
    idle_ticks(9);
    write_reg(spi_mbe_pkg::REG_SEL_ACT_LOW, 16'h0001);
    idle_ticks(2);
    write_reg(REG_NONE, 16'hFFFF);
    write_reg(spi_mbe_pkg::REG_HALF_PERIOD, 16'd1);
    idle_ticks(2);
  endtask

  task automatic test_spi_modes();
    for (int m = 0; m < 4; m++) begin
      write_reg(spi_mbe_pkg::REG_SPI_MODE, 16'(m));
      write_reg(spi_mbe_pkg::REG_SEL_ACT_LOW, 16'(m & 1));
      issue(spi_mbe_pkg::OP_SELECT, 8'h00, 1'b0);
      issue(spi_mbe_pkg::OP_XFER, 8'($urandom), 1'b0);
      issue(spi_mbe_pkg::OP_RELEASE, 8'h00, 1'b0);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    int unsigned nbytes;
    logic [15:0] half;
    target = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < target) begin
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      noise_pct = ($urandom_range(0, 2) == 0) ? 5 : 0;
      if ($urandom_range(0, 1)) write_reg(spi_mbe_pkg::REG_SPI_MODE, 16'($urandom));
      if ($urandom_range(0, 1)) write_reg(spi_mbe_pkg::REG_MSB_FIRST, 16'($urandom));
      if ($urandom_range(0, 2) == 0) write_reg(spi_mbe_pkg::REG_SEL_ACT_LOW, 16'($urandom));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4:  half = 16'($urandom_range(2, 4));
          5:              half = 16'($urandom_range(5, 12));
          default:        half = 16'd1;
        endcase
        write_reg(spi_mbe_pkg::REG_HALF_PERIOD, half);
      end
      case ($urandom_range(0, 9))
        0: begin
          // noise: random commands and fields
          repeat ($urandom_range(4, 30))
            send_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 8'($urandom),
                      draw_miso());
        end
        1, 2: begin
          // cut short, the next setting can land mid-byte
          send_tick(1'b1, 3'($urandom_range(0, 2)), 8'($urandom), draw_miso());
          idle_ticks($urandom_range(1, 20));
        end
        default: begin
          issue(spi_mbe_pkg::OP_SELECT, 8'($urandom), $urandom_range(0, 7) == 0);
          nbytes = $urandom_range(1, 4);
          repeat (nbytes) begin
            idle_ticks($urandom_range(0, 3));
            issue(3'($urandom_range(0, 2)), 8'($urandom), $urandom_range(0, 7) == 0);
          end
          idle_ticks($urandom_range(0, 2));
          issue(spi_mbe_pkg::OP_RELEASE, 8'($urandom), $urandom_range(0, 7) == 0);
        end
      endcase
    end
  endtask

  initial begin : result_checker
    pin_state_t got;
    pin_state_t want;
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got = '{out_ch.sck_level, out_ch.mosi_level, out_ch.select_level, out_ch.busy_res,
              out_ch.done_res, out_ch.rx_valid, out_ch.rx_byte, out_ch.status};
      results_seen++;
      if (predicted_pins.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = predicted_pins.pop_front();
        check_field("sck_level", 8'(got.sck), 8'(want.sck));
        check_field("mosi_level", 8'(got.mosi), 8'(want.mosi));
        check_field("select_level", 8'(got.sel), 8'(want.sel));
        check_field("busy_res", 8'(got.busy), 8'(want.busy));
        check_field("done_res", 8'(got.done), 8'(want.done));
        check_field("rx_valid", 8'(got.rxv), 8'(want.rxv));
        check_field("rx_byte", got.rxb, want.rxb);
        check_field("status", 8'(got.stat), 8'(want.stat));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd_valid  <= 1'b0;
    in_ch.opcode     <= spi_mbe_pkg::OP_WRITE;
    in_ch.tx_byte    <= 8'h00;
    in_ch.miso_level <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= spi_mbe_pkg::REG_SPI_MODE;
    cfg_ch.data      <= '0;
    reset_shadow();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_levels();
    test_directed_commands();
    test_config_abort();
    test_spi_modes();
    test_random_traffic();
    in_ch.valid <= 1'b0;
    while (predicted_pins.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
